### rtl/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
package ffba_pkg;

	localparam int DEF_MAX_SEGMENTS = 16;
	localparam int DEF_OFFSET_BITS = 16;

	localparam int SIZE_W = 17;
	localparam int REL_W = 16;
	localparam int BOFS_W = 16;
	localparam int STATUS_W = 2;

	localparam logic [SIZE_W-1:0] HEAP_RESET = 17'd100;
	localparam logic [SIZE_W-1:0] HEAP_ABS_MAX = 17'h10000;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK = 2'd0,
		ST_NO_FIT = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CK,
		S_NEXT_RD,
		S_NEXT_CK,
		S_MERGE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_WR_REM,
		S_WR_FRONT,
		S_DONE
	} state_t;

endpackage

### rtl/ffba_seg_ram.sv
// Segment table memory: one write port, one registered read port.
module ffba_seg_ram
	import ffba_pkg::*;
#(
	parameter int WIDTH = 34,
	parameter int DEPTH = DEF_MAX_SEGMENTS,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/first_fit_block_allocator_core.sv
// Top level of the first-fit block allocator with coalescing.
//
// Requests arrive on the s_ channel: s_tuser is the mode (0 allocate, 1 free),
// s_tdata carries request_size and release_offset. Each request yields one
// result on the m_ channel: m_tdata is block_offset, m_tuser is status.
// The segment table lives in a single-port-write, registered-read memory and
// is walked one entry at a time by a small sequencer: each entry is read
// (S_SCAN_RD) and then checked (S_SCAN_CK). A hit may go on to read the
// successor, merge, shift entries and write the remainder and the front.
// The next request is accepted only once the result is in the output register.
// s_tready is high only while the sequencer is idle.
// cfg_wr_en writes heap_size (saturated to the addressable limit) and
// rebuilds the table as one free segment in the same cycle; write it only
// while idle. After reset the table holds one free segment of 100 bytes;
// the S_INIT state after reset writes it, with s_tready low.
// A finished result waits in the output register; while m_tready is low the
// sequencer holds the next result and accepts no new request.
module first_fit_block_allocator_core
	import ffba_pkg::*;
#(
	parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
	parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [39:0]       s_tdata,   // request_size[16:0], release_offset[32:17], zero
	input  logic              s_tuser,   // mode
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,   // block_offset[15:0]
	output logic [1:0]        m_tuser,   // status[1:0]
	input  logic              cfg_wr_en,
	input  logic [SIZE_W-1:0] cfg_wr_data
);

	localparam int OB = OFFSET_BITS;
	localparam int LEN_W = OB + 1;
	localparam int CW = (LEN_W > SIZE_W) ? LEN_W : SIZE_W;
	localparam int EW = OB + LEN_W + 1;
	localparam int IDX_W = $clog2(MAX_SEGMENTS);
	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
	localparam logic [SIZE_W-1:0] HEAP_LIM =
		(OB >= 16) ? HEAP_ABS_MAX : SIZE_W'(64'd1 << OB);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	state_t state_q, state_d;

	logic [CNT_W-1:0] cnt_q, scan_q, src_q, dst_q, left_q;
	logic             up_q;
	logic [1:0]       drop_q;
	logic             mode_q;
	logic [SIZE_W-1:0] size_q;
	logic [OB-1:0]    rel_q;
	logic [OB-1:0]    cur_start_q, prev_start_q;
	logic [LEN_W-1:0] cur_len_q, prev_len_q;
	logic             prev_used_q;
	logic [OB-1:0]    res_ofs_q;
	status_t          res_st_q;
	logic             m_valid_q;
	logic [15:0]      m_data_q;
	logic [1:0]       m_user_q;

	logic             we;
	logic [IDX_W-1:0] waddr, raddr;
	logic [EW-1:0]    wdata, rdata;

	logic [OB-1:0]    rd_start;
	logic [LEN_W-1:0] rd_len;
	logic             rd_used;
	logic [CW-1:0]    rd_len_c, size_c, cur_len_c, cur_start_c;
	logic             hit;
	logic             s_acc;
	logic [OB+REL_W-1:0] rel_ext;
	logic [SIZE_W-1:0] heap_sat;
	logic [SIZE_W+LEN_W-1:0] heap_ext;
	logic [OB+15:0]   res_ext;
	logic [LEN_W-1:0] merged_prev_len, merged_next_len;
	logic             merge_prev;
	logic [CNT_W-1:0] drop_pos, drop_src, scan_p1, scan_m1;
	logic [1:0]       drop_tot;

	ffba_seg_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_SEGMENTS),
		.AW(IDX_W)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd_start = rdata[EW-1 -: OB];
	assign rd_len = rdata[LEN_W:1];
	assign rd_used = rdata[0];
	assign rd_len_c = CW'(rd_len);
	assign size_c = CW'(size_q);
	assign cur_len_c = CW'(cur_len_q);
	assign cur_start_c = CW'(cur_start_q);
	assign hit = (mode_q == MODE_ALLOC) ? (!rd_used && (rd_len_c >= size_c))
		: (rd_used && (rd_start == rel_q));

	assign s_tready = (state_q == S_IDLE);
	assign s_acc = s_tvalid && s_tready;
	assign rel_ext = {{OB{1'b0}}, s_tdata[32:17]};
	assign heap_sat = (cfg_wr_data > HEAP_LIM) ? HEAP_LIM : cfg_wr_data;
	assign heap_ext = {{LEN_W{1'b0}}, heap_sat};
	assign res_ext = {16'd0, res_ofs_q};

	assign scan_p1 = scan_q + CNT_ONE;
	assign scan_m1 = scan_q - CNT_ONE;
	assign merge_prev = (scan_q != '0) && !prev_used_q;
	assign merged_prev_len = prev_len_q + cur_len_q;
	assign merged_next_len = cur_len_q + rd_len;
	assign drop_tot = drop_q + {1'b0, merge_prev};
	assign drop_pos = merge_prev ? scan_q : scan_p1;
	assign drop_src = drop_pos + CNT_W'(drop_tot);

	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;
	assign m_tuser = m_user_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: state_d = S_IDLE;
			S_IDLE: begin
				if (s_acc) begin
					if (s_tuser == MODE_ALLOC && s_tdata[SIZE_W-1:0] == '0) begin
						state_d = S_DONE;
					end else begin
						state_d = S_SCAN_RD;
					end
				end
			end
			S_SCAN_RD: state_d = (scan_q == cnt_q) ? S_DONE : S_SCAN_CK;
			S_SCAN_CK: begin
				if (!hit) begin
					state_d = S_SCAN_RD;
				end else if (mode_q == MODE_FREE) begin
					state_d = (scan_p1 < cnt_q) ? S_NEXT_RD : S_MERGE;
				end else if (rd_len_c == size_c) begin
					state_d = S_WR_FRONT;
				end else if (cnt_q == CNT_MAX) begin
					state_d = S_DONE;
				end else if (cnt_q - scan_p1 == '0) begin
					state_d = S_WR_REM;
				end else begin
					state_d = S_SHIFT_RD;
				end
			end
			S_NEXT_RD: state_d = S_NEXT_CK;
			S_NEXT_CK: state_d = S_MERGE;
			S_MERGE: begin
				state_d = (drop_tot == 2'd0 || cnt_q == drop_src) ? S_DONE : S_SHIFT_RD;
			end
			S_SHIFT_RD: state_d = S_SHIFT_WR;
			S_SHIFT_WR: begin
				if (left_q == CNT_ONE) begin
					state_d = up_q ? S_WR_REM : S_DONE;
				end else begin
					state_d = S_SHIFT_RD;
				end
			end
			S_WR_REM: state_d = S_WR_FRONT;
			S_WR_FRONT: state_d = S_DONE;
			S_DONE: state_d = (!m_valid_q || m_tready) ? S_IDLE : S_DONE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = scan_q[IDX_W-1:0];
		case (state_q)
			S_INIT: begin
				we = 1'b1;
				wdata = {{OB{1'b0}}, LEN_W'(HEAP_RESET), 1'b0};
			end
			S_IDLE: begin
				we = cfg_wr_en;
				wdata = {{OB{1'b0}}, heap_ext[LEN_W-1:0], 1'b0};
			end
			S_NEXT_RD: raddr = scan_p1[IDX_W-1:0];
			S_MERGE: begin
				we = 1'b1;
				if (merge_prev) begin
					waddr = scan_m1[IDX_W-1:0];
					wdata = {prev_start_q, merged_prev_len, 1'b0};
				end else begin
					waddr = scan_q[IDX_W-1:0];
					wdata = {cur_start_q, cur_len_q, 1'b0};
				end
			end
			S_SHIFT_RD: raddr = src_q[IDX_W-1:0];
			S_SHIFT_WR: begin
				we = 1'b1;
				waddr = dst_q[IDX_W-1:0];
				wdata = rdata;
			end
			S_WR_REM: begin
				we = 1'b1;
				waddr = scan_p1[IDX_W-1:0];
				wdata = {OB'(cur_start_c + size_c), LEN_W'(cur_len_c - size_c), 1'b0};
			end
			S_WR_FRONT: begin
				we = 1'b1;
				waddr = scan_q[IDX_W-1:0];
				wdata = {cur_start_q, LEN_W'(size_c), 1'b1};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cnt_q <= CNT_ONE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cfg_wr_en) begin
						cnt_q <= (heap_sat == '0) ? '0 : CNT_ONE;
					end
				end
				S_MERGE: cnt_q <= cnt_q - CNT_W'(drop_tot);
				S_WR_REM: cnt_q <= cnt_q + CNT_ONE;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mode_q <= s_tuser;
				size_q <= s_tdata[SIZE_W-1:0];
				rel_q <= rel_ext[OB-1:0];
				scan_q <= '0;
				drop_q <= 2'd0;
				prev_used_q <= 1'b1;
				res_ofs_q <= '0;
				res_st_q <= ST_NO_FIT;
			end
			S_SCAN_RD: begin
				if (scan_q == cnt_q) begin
					res_st_q <= (mode_q == MODE_ALLOC) ? ST_NO_FIT : ST_NOT_FOUND;
				end
			end
			S_SCAN_CK: begin
				cur_start_q <= rd_start;
				cur_len_q <= rd_len;
				if (!hit) begin
					prev_start_q <= rd_start;
					prev_len_q <= rd_len;
					prev_used_q <= rd_used;
					scan_q <= scan_p1;
				end else if (mode_q == MODE_ALLOC) begin
					res_st_q <= ST_FULL;
					up_q <= 1'b1;
					src_q <= cnt_q - CNT_ONE;
					dst_q <= cnt_q;
					left_q <= cnt_q - scan_p1;
				end
			end
			S_NEXT_CK: begin
				if (!rd_used) begin
					cur_len_q <= merged_next_len;
					drop_q <= 2'd1;
				end
			end
			S_MERGE: begin
				res_st_q <= ST_OK;
				res_ofs_q <= rel_q;
				up_q <= 1'b0;
				dst_q <= drop_pos;
				src_q <= drop_src;
				left_q <= cnt_q - drop_src;
			end
			S_SHIFT_WR: begin
				left_q <= left_q - CNT_ONE;
				if (up_q) begin
					src_q <= src_q - CNT_ONE;
					dst_q <= dst_q - CNT_ONE;
				end else begin
					src_q <= src_q + CNT_ONE;
					dst_q <= dst_q + CNT_ONE;
				end
			end
			S_WR_FRONT: begin
				res_st_q <= ST_OK;
				res_ofs_q <= cur_start_q;
			end
			S_DONE: begin
				if (!m_valid_q || m_tready) begin
					m_data_q <= (res_st_q == ST_OK) ? res_ext[15:0] : 16'd0;
					m_user_q <= res_st_q;
				end
			end
			default: ;
		endcase
	end

endmodule
